@@ rtl/core/swd_pkg.sv @@
// shared constants, codes and types of the square window detector
`default_nettype none

package swd_pkg;

  localparam int GRID_SIDE_DEF   = 50;
  localparam int WINDOW_SIDE_DEF = 5;
  localparam int FIFO_DEPTH_DEF  = 8;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 6;
  localparam int RUN_W  = 3;
  localparam int CNT_W  = 12;

  localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  typedef enum logic {
    KIND_TARGET = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // one result item
  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   target_row;
    logic [POS_W-1:0]   target_col;
    logic [CNT_W-1:0]   pixel_count;
    logic               size_ok;
    logic               last_of_run;
  } swd_res_t;

  // request handed from the front stage to the run update stage
  typedef struct packed {
    logic               valid;
    logic               pixel;
    logic               set;
    logic               eom;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               first_row;
    logic               last_col;
    logic [CNT_W-1:0]   count;
    logic               size_ok;
  } swd_op_t;

endpackage

`default_nettype wire

@@ rtl/core/swd_if.sv @@
// valid/ready channels for characters in and results out
`default_nettype none

interface swd_char_if;
  logic                       valid;
  logic                       ready;
  logic [swd_pkg::CHAR_W-1:0] char_code;
  logic                       end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

interface swd_res_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [swd_pkg::POS_W-1:0] target_row;
  logic [swd_pkg::POS_W-1:0] target_col;
  logic [swd_pkg::CNT_W-1:0] pixel_count;
  logic                      size_ok;
  logic                      last_of_run;

  modport source (output valid, output kind, output target_row, output target_col,
                  output pixel_count, output size_ok, output last_of_run, input ready);
  modport sink   (input valid, input kind, input target_row, input target_col,
                  input pixel_count, input size_ok, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/core/swd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module swd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/swd_front.sv @@
// front stage: character filter, raster position, pixel count and run read
`default_nettype none

module swd_front #(
  parameter int GRID_SIDE = swd_pkg::GRID_SIDE_DEF,
  localparam int ADDR_W   = $clog2(GRID_SIDE)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [swd_pkg::CHAR_W-1:0] char_i,
  input  wire logic                       eom_i,
  output logic                            rd_en_o,
  output logic      [ADDR_W-1:0]          rd_addr_o,
  output swd_pkg::swd_op_t                op_o
);

  import swd_pkg::*;

  localparam int TOTAL = GRID_SIDE * GRID_SIDE;

  logic [POS_W-1:0] col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] pix_q, pix_d;
  swd_op_t          op_q, op_d;

  logic             is_pix;
  logic             in_range;
  logic             last_col;
  logic [CNT_W-1:0] pix_inc;

  assign is_pix   = accept_i && (char_i != CH_SPACE) && (char_i != CH_NEWLINE);
  assign in_range = (pix_q < CNT_W'(TOTAL)) && (col_q < POS_W'(GRID_SIDE))
                    && (row_q < POS_W'(GRID_SIDE));
  assign last_col = (col_q == POS_W'(GRID_SIDE - 1));
  assign pix_inc  = (is_pix && (pix_q != CNT_MAX)) ? pix_q + CNT_W'(1) : pix_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pix_d = pix_inc;
    if (is_pix && in_range) begin
      if (last_col) begin
        col_d = '0;
        row_d = row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
    if (accept_i && eom_i) begin
      col_d = '0;
      row_d = '0;
      pix_d = '0;
    end
  end

  always_comb begin
    op_d.valid     = accept_i;
    op_d.pixel     = is_pix && in_range;
    op_d.set       = (char_i == CH_ONE);
    op_d.eom       = eom_i;
    op_d.col       = col_q;
    op_d.row       = row_q;
    op_d.first_row = (row_q == '0);
    op_d.last_col  = last_col;
    op_d.count     = pix_inc;
    op_d.size_ok   = (pix_inc == CNT_W'(TOTAL));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pix_q <= '0;
      op_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pix_q <= pix_d;
      op_q  <= op_d;
    end
  end

  assign rd_en_o   = is_pix && in_range;
  assign rd_addr_o = col_q[ADDR_W-1:0];
  assign op_o      = op_q;

endmodule

`default_nettype wire

@@ rtl/core/swd_back.sv @@
// run update stage: vertical and horizontal runs, write back, result forming
`default_nettype none

module swd_back #(
  parameter int GRID_SIDE   = swd_pkg::GRID_SIDE_DEF,
  parameter int WINDOW_SIDE = swd_pkg::WINDOW_SIDE_DEF,
  localparam int ADDR_W     = $clog2(GRID_SIDE)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire swd_pkg::swd_op_t          op_i,
  input  wire logic [swd_pkg::RUN_W-1:0] rd_data_i,
  output logic                           wr_en_o,
  output logic      [ADDR_W-1:0]         wr_addr_o,
  output logic      [swd_pkg::RUN_W-1:0] wr_data_o,
  output logic      [1:0]                push_o,
  output swd_pkg::swd_res_t              slot0_o,
  output swd_pkg::swd_res_t              slot1_o
);

  import swd_pkg::*;

  localparam logic [RUN_W-1:0] WIN = RUN_W'(WINDOW_SIDE);

  logic [RUN_W-1:0] row_run_q, row_run_d;
  logic [RUN_W-1:0] prev_col, prev_row, vr, hr;
  logic             hit;
  swd_res_t         target, status;

  assign prev_col = op_i.first_row ? '0 : rd_data_i;
  assign prev_row = (op_i.col == '0) ? '0 : row_run_q;
  assign vr       = !op_i.set ? '0 : ((prev_col >= WIN) ? WIN : prev_col + RUN_W'(1));
  assign hr       = (vr < WIN) ? '0 : ((prev_row >= WIN) ? WIN : prev_row + RUN_W'(1));
  assign hit      = op_i.valid && op_i.pixel && (hr >= WIN);

  always_comb begin
    row_run_d = row_run_q;
    if (op_i.valid && op_i.pixel) begin
      row_run_d = op_i.last_col ? '0 : hr;
    end
    if (op_i.valid && op_i.eom) begin
      row_run_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_run_q <= '0;
    end else begin
      row_run_q <= row_run_d;
    end
  end

  assign wr_en_o   = op_i.valid && op_i.pixel;
  assign wr_addr_o = op_i.col[ADDR_W-1:0];
  assign wr_data_o = vr;

  always_comb begin
    target.kind        = KIND_TARGET;
    target.target_row  = op_i.row - POS_W'(WINDOW_SIDE - 1);
    target.target_col  = op_i.col - POS_W'(WINDOW_SIDE - 1);
    target.pixel_count = '0;
    target.size_ok     = 1'b0;
    target.last_of_run = !op_i.eom;

    status.kind        = KIND_STATUS;
    status.target_row  = '0;
    status.target_col  = '0;
    status.pixel_count = op_i.count;
    status.size_ok     = op_i.size_ok;
    status.last_of_run = 1'b1;

    if (hit) begin
      slot0_o = target;
      slot1_o = status;
      push_o  = {op_i.eom, 1'b1};
    end else begin
      slot0_o = status;
      slot1_o = status;
      push_o  = {1'b0, op_i.valid && op_i.eom};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swd_res_fifo.sv @@
// result queue taking up to two results a cycle, one out per cycle while the sink is ready
`default_nettype none

module swd_res_fifo #(
  parameter int DEPTH = swd_pkg::FIFO_DEPTH_DEF,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         push_i,
  input  wire swd_pkg::swd_res_t  slot0_i,
  input  wire swd_pkg::swd_res_t  slot1_i,
  input  wire logic               pop_ready_i,
  output logic                    valid_o,
  output swd_pkg::swd_res_t       data_o,
  output logic                    space_o
);

  import swd_pkg::*;

  swd_res_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic [PTR_W:0]   n_push;
  logic             pop;

  assign n_push = (PTR_W+1)'(push_i[0]) + (PTR_W+1)'(push_i[1]);
  assign pop    = (cnt_q != '0) && pop_ready_i;
  assign wr_d   = wr_q + n_push[PTR_W-1:0];
  assign rd_d   = pop ? rd_q + PTR_W'(1) : rd_q;
  assign cnt_d  = cnt_q + n_push - (PTR_W+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= slot0_i;
    end
    if (push_i[1]) begin
      mem_q[wr_q + PTR_W'(1)] <= slot1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // room for the request in flight and the next one, two results each
  assign space_o = (cnt_q <= (PTR_W+1)'(DEPTH - 4));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

endmodule

`default_nettype wire

@@ rtl/core/square_window_detector.sv @@
// top level of the square window detector
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    char_code, end_of_message
//   res_o    out  valid/ready    kind, target_row, target_col, pixel_count,
//                                size_ok, last_of_run
//
// one character a cycle while ready is high; a two stage pipeline around the column run ram:
// the front stage reads the run, the next cycle updates it and writes it back
// results go from the update stage through an eight entry queue
// ready drops while the queue holds more than four results
// reset clears positions, counters and the queue; the run ram needs no clearing
`default_nettype none

module square_window_detector #(
  parameter int GRID_SIDE   = swd_pkg::GRID_SIDE_DEF,
  parameter int WINDOW_SIDE = swd_pkg::WINDOW_SIDE_DEF
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  swd_char_if.sink     req_i,
  swd_res_if.source    res_o
);

  import swd_pkg::*;

  localparam int ADDR_W = $clog2(GRID_SIDE);

  logic             accept;
  logic             space;
  logic             rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [RUN_W-1:0] rd_data, wr_data;
  logic [1:0]       push;
  swd_op_t          op;
  swd_res_t         slot0, slot1, head;

  assign req_i.ready = space;
  assign accept      = req_i.valid && space;

  swd_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_i    (req_i.char_code),
    .eom_i     (req_i.end_of_message),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .op_o      (op)
  );

  swd_ram #(
    .WIDTH (RUN_W),
    .DEPTH (GRID_SIDE)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  swd_back #(
    .GRID_SIDE   (GRID_SIDE),
    .WINDOW_SIDE (WINDOW_SIDE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .slot0_o   (slot0),
    .slot1_o   (slot1)
  );

  swd_res_fifo #(
    .DEPTH (FIFO_DEPTH_DEF)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .slot0_i     (slot0),
    .slot1_i     (slot1),
    .pop_ready_i (res_o.ready),
    .valid_o     (res_o.valid),
    .data_o      (head),
    .space_o     (space)
  );

  assign res_o.kind        = head.kind;
  assign res_o.target_row  = head.target_row;
  assign res_o.target_col  = head.target_col;
  assign res_o.pixel_count = head.pixel_count;
  assign res_o.size_ok     = head.size_ok;
  assign res_o.last_of_run = head.last_of_run;

endmodule

`default_nettype wire

@@ rtl/core/swd_checker.sv @@
// port level assertions of the square window detector and their binding
`default_nettype none

module swd_checker #(
  parameter int GRID_SIDE   = swd_pkg::GRID_SIDE_DEF,
  parameter int WINDOW_SIDE = swd_pkg::WINDOW_SIDE_DEF
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      valid_i,
  input wire logic                      ready_i,
  input wire logic                      kind_i,
  input wire logic [swd_pkg::POS_W-1:0] row_i,
  input wire logic [swd_pkg::POS_W-1:0] col_i,
  input wire logic [swd_pkg::CNT_W-1:0] count_i,
  input wire logic                      size_ok_i,
  input wire logic                      last_i
);

  import swd_pkg::*;

  localparam logic [POS_W-1:0] MAX_CORNER = POS_W'(GRID_SIDE - WINDOW_SIDE);
  localparam logic [CNT_W-1:0] TOTAL      = CNT_W'(GRID_SIDE * GRID_SIDE);

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_STATUS) |-> (row_i == '0) && (col_i == '0) && last_i)
    else $error("status result with corner or without end mark");

  a_target_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_TARGET) |-> (count_i == '0) && !size_ok_i)
    else $error("target result with count or size flag");

  a_corner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_TARGET) |-> (row_i <= MAX_CORNER) && (col_i <= MAX_CORNER))
    else $error("window corner outside raster");

  a_size_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (kind_i == KIND_STATUS) |-> (size_ok_i == (count_i == TOTAL)))
    else $error("size flag disagrees with pixel count");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(row_i) && $stable(col_i))
    else $error("stalled result changed");

endmodule

bind square_window_detector swd_checker #(
  .GRID_SIDE   (GRID_SIDE),
  .WINDOW_SIDE (WINDOW_SIDE)
) u_swd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_i   (res_o.valid),
  .ready_i   (res_o.ready),
  .kind_i    (res_o.kind),
  .row_i     (res_o.target_row),
  .col_i     (res_o.target_col),
  .count_i   (res_o.pixel_count),
  .size_ok_i (res_o.size_ok),
  .last_i    (res_o.last_of_run)
);

`default_nettype wire

@@ verif/swd_window_checker.sv @@
// checker: predicts the window and status results of the detector and compares them
`timescale 1ns / 1ps

module swd_window_checker #(
  parameter int GRID_SIDE   = swd_pkg::GRID_SIDE_DEF,
  parameter int WINDOW_SIDE = swd_pkg::WINDOW_SIDE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  swd_char_if  req_i,
  swd_res_if   res_i,
  output int   fault_count_o,
  output int   pending_reports_o
);

  import swd_pkg::*;

  localparam int REPORT_CAP = 100;

  logic [RUN_W-1:0] column_run_q [GRID_SIDE];
  logic [RUN_W-1:0] row_run_q;
  logic [POS_W-1:0] col_pos_q;
  logic [POS_W-1:0] row_pos_q;
  logic [CNT_W-1:0] pixel_total_q;
  swd_res_t         window_reports_q [$];
  int               faults = 0;

  assign fault_count_o = faults;

  function automatic string describe(input swd_res_t r);
    return $sformatf("kind %0d row %0d col %0d count %0d size_ok %0d last %0d",
                     r.kind, r.target_row, r.target_col, r.pixel_count, r.size_ok,
                     r.last_of_run);
  endfunction

  task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic eom);
    swd_res_t found [2];
    int       n_found;
    int       col_above;
    int       row_left;
    int       vert;
    int       horiz;
    n_found = 0;
    if (ch != CH_SPACE && ch != CH_NEWLINE) begin
      if (int'(pixel_total_q) < GRID_SIDE * GRID_SIDE && int'(col_pos_q) < GRID_SIDE
          && int'(row_pos_q) < GRID_SIDE) begin
        // row 0 never looks at stored column runs
        col_above = (row_pos_q == '0) ? 0 : int'(column_run_q[col_pos_q]);
        row_left  = (col_pos_q == '0) ? 0 : int'(row_run_q);
        vert  = 0;
        horiz = 0;
        if (ch == CH_ONE) begin
          vert = (col_above >= WINDOW_SIDE) ? WINDOW_SIDE : col_above + 1;
        end
        if (vert >= WINDOW_SIDE) begin
          horiz = (row_left >= WINDOW_SIDE) ? WINDOW_SIDE : row_left + 1;
        end
        column_run_q[col_pos_q] = RUN_W'(vert);
        row_run_q = RUN_W'(horiz);
        if (horiz >= WINDOW_SIDE) begin
          found[n_found]            = '0;
          found[n_found].kind       = KIND_TARGET;
          found[n_found].target_row = POS_W'(int'(row_pos_q) + 1 - WINDOW_SIDE);
          found[n_found].target_col = POS_W'(int'(col_pos_q) + 1 - WINDOW_SIDE);
          n_found++;
        end
        if (int'(col_pos_q) + 1 >= GRID_SIDE) begin
          col_pos_q = '0;
          row_pos_q = row_pos_q + 1'b1;
          row_run_q = '0;
        end else begin
          col_pos_q = col_pos_q + 1'b1;
        end
      end
      if (pixel_total_q != CNT_MAX) begin
        pixel_total_q = pixel_total_q + 1'b1;
      end
    end
    if (eom) begin
      found[n_found]             = '0;
      found[n_found].kind        = KIND_STATUS;
      found[n_found].pixel_count = pixel_total_q;
      found[n_found].size_ok     = (int'(pixel_total_q) == GRID_SIDE * GRID_SIDE);
      n_found++;
      row_run_q     = '0;
      col_pos_q     = '0;
      row_pos_q     = '0;
      pixel_total_q = '0;
    end
    if (n_found > 0) begin
      found[n_found - 1].last_of_run = 1'b1;
    end
    for (int i = 0; i < n_found; i++) begin
      window_reports_q.insert(window_reports_q.size(), found[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    swd_res_t got;
    swd_res_t want;
    if (!rst_ni) begin
      row_run_q     = '0;
      col_pos_q     = '0;
      row_pos_q     = '0;
      pixel_total_q = '0;
      window_reports_q.delete();
    end else begin
      // a result never leaves in the same cycle as its request, so retire first
      if (res_i.valid && res_i.ready) begin
        got.kind        = kind_e'(res_i.kind);
        got.target_row  = res_i.target_row;
        got.target_col  = res_i.target_col;
        got.pixel_count = res_i.pixel_count;
        got.size_ok     = res_i.size_ok;
        got.last_of_run = res_i.last_of_run;
        if (window_reports_q.size() == 0) begin
          if (faults < REPORT_CAP) begin
            $display("%0t: result with none expected, actual %s", $time, describe(got));
          end
          faults++;
        end else begin
          want = window_reports_q.pop_front();
          if (got.kind !== want.kind || got.target_row !== want.target_row
              || got.target_col !== want.target_col || got.pixel_count !== want.pixel_count
              || got.size_ok !== want.size_ok || got.last_of_run !== want.last_of_run) begin
            if (faults < REPORT_CAP) begin
              $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                       describe(want), describe(got));
            end
            faults++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_char(req_i.char_code, req_i.end_of_message);
      end
    end
    pending_reports_o = window_reports_q.size();
  end

endmodule

@@ verif/square_window_detector_tb.sv @@
// testbench top: character stimulus, result back-pressure, watchdog and verdict
`timescale 1ns / 1ps

module square_window_detector_tb;
  import swd_pkg::*;

  localparam int GRID           = GRID_SIDE_DEF;
  localparam int WINDOW         = WINDOW_SIDE_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;

  logic clk_i;
  logic rst_ni;
  int   fault_count;
  int   pending_reports;
  int   src_gap_pct  = 33;
  int   snk_gap_pct  = 49;
  logic hold_off_go  = 1'b0;
  int   quiet_cycles = 0;
  int   patch_r0 [2];
  int   patch_c0 [2];
  int   patch_h  [2];
  int   patch_w  [2];

  swd_char_if req_if ();
  swd_res_if  res_if ();

  square_window_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  swd_window_checker window_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_i             (req_if),
    .res_i             (res_if),
    .fault_count_o     (fault_count),
    .pending_reports_o (pending_reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go && !hold_used) begin
        hold_left = LONG_HOLD;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("square_window_detector_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_char(input logic [CHAR_W-1:0] ch, input logic eom);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.char_code      <= ch;
    req_if.end_of_message <= eom;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] pixel_char(input bit set);
    logic [CHAR_W-1:0] c;
    if (set) return CH_ONE;
    if ($urandom_range(0, 7) != 0) return CH_ZERO;
    c = CHAR_W'($urandom_range(0, 255));
    while (c == CH_ONE || c == CH_SPACE || c == CH_NEWLINE) begin
      c = CHAR_W'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic set_patch(input int k, input int r0, input int c0, input int h, input int w);
    patch_r0[k] = r0;
    patch_c0[k] = c0;
    patch_h[k]  = h;
    patch_w[k]  = w;
  endtask

  // one message of n_pix pixels in row order, ones forced inside the two patches
  task automatic send_grid(input int n_pix, input int fill_pct, input bit eom_on_newline);
    int r;
    int c;
    bit set;
    for (int p = 0; p < n_pix; p++) begin
      r   = p / GRID;
      c   = p % GRID;
      set = ($urandom_range(0, 99) < fill_pct);
      for (int k = 0; k < 2; k++) begin
        if (r >= patch_r0[k] && r < patch_r0[k] + patch_h[k]
            && c >= patch_c0[k] && c < patch_c0[k] + patch_w[k]) begin
          set = 1'b1;
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        put_char($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE, 1'b0);
      end
      put_char(pixel_char(set), (p == n_pix - 1) && !eom_on_newline);
      if (c == GRID - 1 && p != n_pix - 1) begin
        put_char(CH_NEWLINE, 1'b0);
      end
    end
    if (eom_on_newline) begin
      put_char(CH_NEWLINE, 1'b1);
    end
  endtask

  task automatic random_message();
    int rows;
    rows = $urandom_range(WINDOW, WINDOW + 2);
    set_patch(0, $urandom_range(0, rows - WINDOW), $urandom_range(0, GRID - WINDOW),
              $urandom_range(WINDOW, rows), $urandom_range(WINDOW, 12));
    set_patch(1, $urandom_range(0, rows - 1), $urandom_range(0, GRID - 1),
              $urandom_range(2, WINDOW + 1), $urandom_range(2, 8));
    send_grid(rows * GRID + $urandom_range(0, GRID - 1), $urandom_range(10, 80),
              $urandom_range(0, 3) == 0);
  endtask

  task automatic noise_burst(input int n);
    repeat (n) put_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    put_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // hold the sender until every expected result is out, then change idling
  task automatic settle(input int src_pct, input int snk_pct);
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_reports != 0);
    src_gap_pct = src_pct;
    snk_gap_pct = snk_pct;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid          <= 1'b0;
    req_if.char_code      <= '0;
    req_if.end_of_message <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dropped characters, lone pixels and end of message on either kind
    put_char(CH_SPACE, 1'b1);
    put_char(CH_NEWLINE, 1'b1);
    put_char(CH_ONE, 1'b1);
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(CH_ZERO, 1'b0);
    put_char(CH_NEWLINE, 1'b0);
    put_char(CH_ONE, 1'b0);
    put_char(CH_SPACE, 1'b0);
    put_char(8'hFF, 1'b1);
    put_char(8'h00, 1'b1);

    // final pixel of a short message completes a window
    set_patch(0, 0, 10, WINDOW, WINDOW);
    set_patch(1, 0, 0, 0, 0);
    send_grid((WINDOW - 1) * GRID + 10 + WINDOW, 0, 1'b0);

    random_message();
    noise_burst(40);

    settle(49, 33);
    random_message();
    noise_burst(40);

    settle(0, 0);
    hold_off_go <= 1'b1;
    repeat (30) put_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
    settle(0, 0);

    noise_burst(40);

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_reports != 0);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("square_window_detector_tb: done, clean");
    end else begin
      $display("square_window_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
